>>> hw/rtl/mbd_pkg.sv
// ============================================================================
// mbd_pkg
// Shared types, codes and wait tables for the memory bus decoder.
// ============================================================================
package mbd_pkg;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int OFFSET_W = 25;
    localparam int CYCLES_W = 5;
    localparam int ROT_W    = 5;
    localparam int WC_W     = 16;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // target codes
    localparam logic [3:0] TGT_NONE    = 4'd0;
    localparam logic [3:0] TGT_BIOS    = 4'd1;
    localparam logic [3:0] TGT_EWRAM   = 4'd2;
    localparam logic [3:0] TGT_IWRAM   = 4'd3;
    localparam logic [3:0] TGT_IO      = 4'd4;
    localparam logic [3:0] TGT_PALETTE = 4'd5;
    localparam logic [3:0] TGT_VRAM    = 4'd6;
    localparam logic [3:0] TGT_OAM     = 4'd7;
    localparam logic [3:0] TGT_ROM     = 4'd8;

    // region codes, address bits 27:24
    localparam logic [3:0] REG_BIOS    = 4'h0;
    localparam logic [3:0] REG_EWRAM   = 4'h2;
    localparam logic [3:0] REG_IWRAM   = 4'h3;
    localparam logic [3:0] REG_IO      = 4'h4;
    localparam logic [3:0] REG_PALETTE = 4'h5;
    localparam logic [3:0] REG_VRAM    = 4'h6;
    localparam logic [3:0] REG_OAM     = 4'h7;
    localparam logic [3:0] REG_SRAM_LO = 4'hE;
    localparam logic [3:0] REG_SRAM_HI = 4'hF;

    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   address;
        logic [1:0]          access_size;
        logic                sequential;
        logic [DATA_W-1:0]   write_data;
    } acc_t;

    typedef struct packed {
        logic [3:0]          target;
        logic [OFFSET_W-1:0] offset;
        logic                write_enable;
        logic [DATA_W-1:0]   store_value;
        logic [1:0]          store_size;
        logic [ROT_W-1:0]    bios_rotate;
        logic [CYCLES_W-1:0] cycles;
    } res_t;

    // first-access waits {4, 3, 2, 8}
    function automatic logic [3:0] first_wait(input logic [1:0] idx);
        logic [3:0] w;
        case (idx)
            2'd0:    w = 4'd4;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd2;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

    // sequential waits {2,1}, {4,1}, {8,1} for areas 0..2
    function automatic logic [3:0] seq_wait(input logic [1:0] area, input logic sel);
        logic [3:0] w;
        if (sel)
        begin
            w = 4'd1;
        end
        else
        begin
            case (area)
                2'd0:    w = 4'd2;
                2'd1:    w = 4'd4;
                default: w = 4'd8;
            endcase
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/mbd_cost.sv
// ============================================================================
// mbd_cost
// Access cycle cost from region, width, sequential flag and wait control.
// ============================================================================
module mbd_cost (
    input  logic [3:0]                  region,
    input  logic                        wide,
    input  logic                        seq,
    input  logic [mbd_pkg::WC_W-1:0]    wait_control,
    output logic [mbd_pkg::CYCLES_W-1:0] cycles
);
    import mbd_pkg::*;

    logic       is_cart;
    logic [1:0] area;
    logic [1:0] n_idx;
    logic       s_sel;
    logic [CYCLES_W-1:0] n_cyc;
    logic [CYCLES_W-1:0] s_cyc;

    assign is_cart = region[3] && !(region[2] && region[1]);
    assign area    = region[2:1];

    always_comb
    begin
        case (area)
            2'd0:
            begin
                n_idx = wait_control[3:2];
                s_sel = wait_control[4];
            end
            2'd1:
            begin
                n_idx = wait_control[6:5];
                s_sel = wait_control[7];
            end
            default:
            begin
                n_idx = wait_control[9:8];
                s_sel = wait_control[10];
            end
        endcase
    end

    assign n_cyc = {1'b0, first_wait(n_idx)} + 5'd1;
    assign s_cyc = {1'b0, seq_wait(area, s_sel)} + 5'd1;

    always_comb
    begin
        case (region)
            REG_EWRAM:
                cycles = wide ? 5'd6 : 5'd3;
            REG_PALETTE, REG_VRAM:
                cycles = wide ? 5'd2 : 5'd1;
            REG_SRAM_LO, REG_SRAM_HI:
                cycles = {1'b0, first_wait(wait_control[1:0])} + 5'd1;
            default:
            begin
                if (is_cart)
                begin
                    if (wide)
                        cycles = seq ? (s_cyc + s_cyc) : (n_cyc + s_cyc);
                    else
                        cycles = seq ? s_cyc : n_cyc;
                end
                else
                begin
                    cycles = 5'd1;
                end
            end
        endcase
    end

endmodule

>>> hw/rtl/mbd_decode.sv
// ============================================================================
// mbd_decode
// Region decode, alignment, offset masking and store formation for one item.
// ============================================================================
module mbd_decode (
    input  mbd_pkg::acc_t               acc,
    input  logic [mbd_pkg::WC_W-1:0]    wait_control,
    output mbd_pkg::res_t               res
);
    import mbd_pkg::*;

    logic [1:0]          size;
    logic                wide;
    logic [ADDR_W-1:0]   a;
    logic [7:0]          region;
    logic                low_map;
    logic [CYCLES_W-1:0] cost;
    logic [DATA_W-1:0]   sval;

    always_comb
    begin
        if (acc.access_size == SIZE_BYTE)
            size = SIZE_BYTE;
        else if (acc.access_size == SIZE_HALF)
            size = SIZE_HALF;
        else
            size = SIZE_WORD;
    end

    assign wide = (size == SIZE_WORD);

    always_comb
    begin
        a = acc.address;
        if (size == SIZE_HALF)
            a[0] = 1'b0;
        else if (size == SIZE_WORD)
            a[1:0] = 2'b00;
    end

    assign region  = a[31:24];
    assign low_map = (region[7:4] == 4'h0);

    mbd_cost u_cost (
        .region       (region[3:0]),
        .wide         (wide),
        .seq          (acc.sequential),
        .wait_control (wait_control),
        .cycles       (cost)
    );

    always_comb
    begin
        case (size)
            SIZE_BYTE: sval = {24'd0, acc.write_data[7:0]};
            SIZE_HALF: sval = {16'd0, acc.write_data[15:0]};
            default:   sval = acc.write_data;
        endcase
    end

    always_comb
    begin
        res.target       = TGT_NONE;
        res.offset       = '0;
        res.write_enable = 1'b0;
        res.store_value  = sval;
        res.store_size   = size;
        res.bios_rotate  = '0;
        res.cycles       = cost;

        if (low_map)
        begin
            case (region[3:0])
                REG_BIOS:
                begin
                    res.target = TGT_BIOS;
                    res.offset = {a[24:2], 2'b00};
                    if (!acc.command)
                        res.bios_rotate = {a[1:0], 3'b000};
                end
                REG_EWRAM:
                begin
                    res.target       = TGT_EWRAM;
                    res.offset       = {7'd0, a[17:0]};
                    res.write_enable = acc.command;
                end
                REG_IWRAM:
                begin
                    res.target       = TGT_IWRAM;
                    res.offset       = {10'd0, a[14:0]};
                    res.write_enable = acc.command;
                end
                REG_IO:
                begin
                    res.target       = TGT_IO;
                    res.offset       = {1'b0, a[23:0]};
                    res.write_enable = acc.command;
                end
                REG_PALETTE, REG_VRAM:
                begin
                    if (region[3:0] == REG_PALETTE)
                    begin
                        res.target = TGT_PALETTE;
                        res.offset = {15'd0, a[9:0]};
                    end
                    else
                    begin
                        // upper 32K mirrors back onto 0x10000
                        res.target = TGT_VRAM;
                        res.offset = {8'd0, a[16], a[15] & ~a[16], a[14:0]};
                    end
                    res.write_enable = acc.command;
                    if (acc.command && size == SIZE_BYTE)
                    begin
                        res.offset[0]   = 1'b0;
                        res.store_value = {16'd0, acc.write_data[7:0],
                                           acc.write_data[7:0]};
                        res.store_size  = SIZE_HALF;
                    end
                end
                REG_OAM:
                begin
                    res.target = TGT_OAM;
                    res.offset = {15'd0, a[9:0]};
                    if (acc.command)
                    begin
                        if (size == SIZE_BYTE)
                            res.cycles = '0;
                        else
                            res.write_enable = 1'b1;
                    end
                end
                default:
                begin
                    if (region[3] && !(region[2] && region[1]))
                    begin
                        res.target = TGT_ROM;
                        res.offset = a[24:0];
                    end
                end
            endcase
        end

        if (!res.write_enable)
        begin
            res.store_value = '0;
            res.store_size  = SIZE_BYTE;
        end
    end

endmodule

>>> hw/rtl/memory_bus_decode_waitstate_top.sv
// ============================================================================
// memory_bus_decode_waitstate_top
// Bus access decoder: target, offset, store and wait-state cycle cost.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one bus access per item:
//   command, address, access_size, sequential, write_data.
//   Output channel (out_valid / out_stall) returns one result item per access:
//   target, offset, write_enable, store_value, store_size, bios_rotate,
//   cycles.
//   wait_control is loaded when wait_control_we is high; load it only while
//   no item is in flight.
//   The input register loads at the accepting edge; the result register
//   loads from the decode between them once the output side is free, and
//   out_valid rises with it.
//   Throughput: one item per cycle unless stalled (single decode stage).
//   Reset clears both valid flags and wait_control to zero.
//   When out_stall is high the result register holds; the input register
//   keeps accepting until it too is full, then in_stall rises.
// ============================================================================
module memory_bus_decode_waitstate_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wait_control_we,
    input  logic [mbd_pkg::WC_W-1:0]        wait_control_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [mbd_pkg::ADDR_W-1:0]      address,
    input  logic [1:0]                      access_size,
    input  logic                            sequential,
    input  logic [mbd_pkg::DATA_W-1:0]      write_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [3:0]                      target,
    output logic [mbd_pkg::OFFSET_W-1:0]    offset,
    output logic                            write_enable,
    output logic [mbd_pkg::DATA_W-1:0]      store_value,
    output logic [1:0]                      store_size,
    output logic [mbd_pkg::ROT_W-1:0]       bios_rotate,
    output logic [mbd_pkg::CYCLES_W-1:0]    cycles
);
    import mbd_pkg::*;

    logic [WC_W-1:0] wait_control_reg;
    logic [WC_W-1:0] wait_control_next;
    logic            in_valid_reg;
    logic            in_valid_next;
    acc_t            acc_reg;
    acc_t            acc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    res_t            res_reg;
    res_t            res_next;
    res_t            res_dec;
    logic            out_free;
    logic            s1_move;
    logic            in_take;

    mbd_decode u_decode (
        .acc          (acc_reg),
        .wait_control (wait_control_reg),
        .res          (res_dec)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        wait_control_next = wait_control_we ? wait_control_data : wait_control_reg;
        in_valid_next     = in_take || (in_valid_reg && !out_free);
        acc_next          = acc_reg;
        if (in_take)
        begin
            acc_next.command     = command;
            acc_next.address     = address;
            acc_next.access_size = access_size;
            acc_next.sequential  = sequential;
            acc_next.write_data  = write_data;
        end
        out_valid_next = s1_move || (out_valid_reg && out_stall);
        res_next       = s1_move ? res_dec : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_control_reg <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            wait_control_reg <= wait_control_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign target       = res_reg.target;
    assign offset       = res_reg.offset;
    assign write_enable = res_reg.write_enable;
    assign store_value  = res_reg.store_value;
    assign store_size   = res_reg.store_size;
    assign bios_rotate  = res_reg.bios_rotate;
    assign cycles       = res_reg.cycles;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("in_stall raised with empty input register");

    a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_stall) |=> out_valid_reg)
        else $error("item left input register but no result appeared");

    a_we_target: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |->
            (target == TGT_EWRAM || target == TGT_IWRAM || target == TGT_IO ||
             target == TGT_PALETTE || target == TGT_VRAM || target == TGT_OAM))
        else $error("store to a read-only or unmapped target");

    a_none_target: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && target == TGT_NONE) |-> (offset == '0 && !write_enable))
        else $error("unmapped access with nonzero offset or store");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (store_value == '0 && store_size == SIZE_BYTE))
        else $error("store fields set without write enable");
`endif

endmodule

>>> tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the bus access decoder with wait-state costing.
// Directed corner accesses are followed by random accesses under several
// wait-control settings. A scoreboard class decodes each accepted access in
// its own model and compares every returned result item field by field.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam int         CLK_PERIOD     = 10;
    localparam int         RAND_PER_PHASE = 188;
    localparam int         NUM_PHASES     = 6;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         HANG_LIMIT     = 3000;

    localparam logic       CMD_READ       = 1'b0;
    localparam logic       CMD_WRITE      = 1'b1;
    localparam logic [1:0] SIZE_ALT_WORD  = 2'd3;
    localparam logic [3:0] REG_ROM_FIRST  = 4'h8;
    localparam logic [3:0] REG_ROM_LAST   = 4'hD;

    class access_board;
        logic [WC_W-1:0] wait_ctl;
        res_t            decoded_q[$];
        int              mismatches;
        int              matched;
        int              noted;
        int unsigned     first_waits[4];
        int unsigned     seq_waits[3];

        function new();
            wait_ctl    = '0;
            mismatches  = 0;
            matched     = 0;
            noted       = 0;
            first_waits = '{4, 3, 2, 8};
            seq_waits   = '{2, 4, 8};
        endfunction

        function logic [CYCLES_W-1:0] access_cost(logic [3:0] nib, logic wide, logic seq);
            int unsigned area;
            int unsigned n;
            int unsigned s;
            int unsigned cost;
            cost = 1;
            case (nib)
                REG_EWRAM:                cost = wide ? 6 : 3;
                REG_PALETTE, REG_VRAM:    cost = wide ? 2 : 1;
                REG_SRAM_LO, REG_SRAM_HI: cost = first_waits[wait_ctl[1:0]] + 1;
                default:
                begin
                    if (nib >= REG_ROM_FIRST && nib <= REG_ROM_LAST)
                    begin
                        area = (int'(nib) - 8) >> 1;
                        n    = first_waits[(wait_ctl >> (2 + 3 * area)) & 2'b11];
                        s    = ((wait_ctl >> (4 + 3 * area)) & 1) ? 1 : seq_waits[area];
                        if (wide)
                            cost = seq ? 2 * (s + 1) : (n + 1) + (s + 1);
                        else
                            cost = seq ? s + 1 : n + 1;
                    end
                end
            endcase
            return CYCLES_W'(cost);
        endfunction

        function res_t decode_access(acc_t a);
            res_t        r;
            logic [1:0]  sz;
            logic [31:0] addr;
            logic [7:0]  region;
            logic        wide;
            logic        wr;
            logic        we;
            logic [16:0] vram_off;
            r      = '0;
            we     = 1'b0;
            wr     = (a.command == CMD_WRITE);
            sz     = (a.access_size == SIZE_ALT_WORD) ? SIZE_WORD : a.access_size;
            wide   = (sz == SIZE_WORD);
            addr   = a.address;
            if (sz == SIZE_HALF)
                addr[0] = 1'b0;
            else if (wide)
                addr[1:0] = 2'b00;
            region = addr[31:24];
            r.cycles = access_cost(region[3:0], wide, a.sequential);
            case (sz)
                SIZE_BYTE: r.store_value = {24'd0, a.write_data[7:0]};
                SIZE_HALF: r.store_value = {16'd0, a.write_data[15:0]};
                default:   r.store_value = a.write_data;
            endcase
            r.store_size = sz;
            if (region[7:4] == 4'h0)
            begin
                case (region[3:0])
                    REG_BIOS:
                    begin
                        r.target = TGT_BIOS;
                        r.offset = {addr[24:2], 2'b00};
                        if (!wr)
                            r.bios_rotate = {addr[1:0], 3'b000};
                    end
                    REG_EWRAM:
                    begin
                        r.target = TGT_EWRAM;
                        r.offset = OFFSET_W'(addr[17:0]);
                        we       = wr;
                    end
                    REG_IWRAM:
                    begin
                        r.target = TGT_IWRAM;
                        r.offset = OFFSET_W'(addr[14:0]);
                        we       = wr;
                    end
                    REG_IO:
                    begin
                        r.target = TGT_IO;
                        r.offset = OFFSET_W'(addr[23:0]);
                        we       = wr;
                    end
                    REG_PALETTE, REG_VRAM:
                    begin
                        if (region[3:0] == REG_PALETTE)
                        begin
                            r.target = TGT_PALETTE;
                            r.offset = OFFSET_W'(addr[9:0]);
                        end
                        else
                        begin
                            r.target = TGT_VRAM;
                            vram_off = addr[16:0];
                            if (vram_off >= 17'h18000)
                                vram_off = vram_off & 17'h17FFF;
                            r.offset = OFFSET_W'(vram_off);
                        end
                        we = wr;
                        // byte store widens to a duplicated halfword
                        if (wr && sz == SIZE_BYTE)
                        begin
                            r.offset[0]   = 1'b0;
                            r.store_value = {16'd0, a.write_data[7:0], a.write_data[7:0]};
                            r.store_size  = SIZE_HALF;
                        end
                    end
                    REG_OAM:
                    begin
                        r.target = TGT_OAM;
                        r.offset = OFFSET_W'(addr[9:0]);
                        if (wr)
                        begin
                            if (sz == SIZE_BYTE)
                                r.cycles = '0;
                            else
                                we = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (region[3:0] >= REG_ROM_FIRST && region[3:0] <= REG_ROM_LAST)
                        begin
                            r.target = TGT_ROM;
                            r.offset = addr[24:0];
                        end
                    end
                endcase
            end
            r.write_enable = we;
            if (!we)
            begin
                r.store_value = '0;
                r.store_size  = '0;
            end
            return r;
        endfunction

        function void note_access(acc_t a);
            decoded_q.push_back(decode_access(a));
            noted++;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
        endtask

        task check_result(res_t got);
            res_t e;
            if (decoded_q.size() == 0)
            begin
                report("result item with no access outstanding");
                return;
            end
            e = decoded_q.pop_front();
            compare_field("target", 32'(got.target), 32'(e.target));
            compare_field("offset", 32'(got.offset), 32'(e.offset));
            compare_field("write_enable", 32'(got.write_enable), 32'(e.write_enable));
            compare_field("store_value", got.store_value, e.store_value);
            compare_field("store_size", 32'(got.store_size), 32'(e.store_size));
            compare_field("bios_rotate", 32'(got.bios_rotate), 32'(e.bios_rotate));
            compare_field("cycles", 32'(got.cycles), 32'(e.cycles));
            matched++;
        endtask
    endclass

    logic                clk               = 1'b0;
    logic                rst_n             = 1'b0;
    logic                wait_control_we   = 1'b0;
    logic [WC_W-1:0]     wait_control_data = '0;
    logic                in_valid          = 1'b0;
    logic                in_stall;
    logic                command           = 1'b0;
    logic [ADDR_W-1:0]   address           = '0;
    logic [1:0]          access_size       = '0;
    logic                sequential        = 1'b0;
    logic [DATA_W-1:0]   write_data        = '0;
    logic                out_valid;
    logic                out_stall         = 1'b0;
    logic [3:0]          target;
    logic [OFFSET_W-1:0] offset;
    logic                write_enable;
    logic [DATA_W-1:0]   store_value;
    logic [1:0]          store_size;
    logic [ROT_W-1:0]    bios_rotate;
    logic [CYCLES_W-1:0] cycles;

    access_board board;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;
    int          wc_writes = 0;
    int          directed_count = 0;

    memory_bus_decode_waitstate_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .wait_control_we   (wait_control_we),
        .wait_control_data (wait_control_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .address           (address),
        .access_size       (access_size),
        .sequential        (sequential),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .target            (target),
        .offset            (offset),
        .write_enable      (write_enable),
        .store_value       (store_value),
        .store_size        (store_size),
        .bios_rotate       (bios_rotate),
        .cycles            (cycles)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result({target, offset, write_enable, store_value,
                                store_size, bios_rotate, cycles});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("[%0t] timeout: no item moved for %0d cycles", $time, HANG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic acc_t make_access(logic cmd, logic [31:0] addr, logic [1:0] size,
                                         logic seq, logic [31:0] data);
        acc_t a;
        a.command     = cmd;
        a.address     = addr;
        a.access_size = size;
        a.sequential  = seq;
        a.write_data  = data;
        return a;
    endfunction

    function automatic acc_t random_access();
        acc_t a;
        a.command     = 1'($urandom_range(1));
        a.address     = $urandom;
        if ($urandom_range(99) < 85)
            a.address[31:28] = 4'h0;
        a.access_size = 2'($urandom_range(3));
        a.sequential  = 1'($urandom_range(1));
        a.write_data  = $urandom;
        return a;
    endfunction

    task automatic send_access(input acc_t a);
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= a.command;
        address     <= a.address;
        access_size <= a.access_size;
        sequential  <= a.sequential;
        write_data  <= a.write_data;
        do
            @(posedge clk);
        while (in_stall);
        board.note_access(a);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wait_control(input logic [WC_W-1:0] value);
        wait_control_we   <= 1'b1;
        wait_control_data <= value;
        @(posedge clk);
        wait_control_we   <= 1'b0;
        board.wait_ctl = value;
        wc_writes++;
    endtask

    task automatic run_directed();
        send_access(make_access(CMD_READ,  32'h0000_0000, SIZE_WORD, 1'b0, 32'h0));
        send_access(make_access(CMD_READ,  32'h0000_0003, SIZE_BYTE, 1'b0, 32'h0));
        send_access(make_access(CMD_READ,  32'h0000_3FFE, SIZE_HALF, 1'b1, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h01FF_FFFF, SIZE_BYTE, 1'b0, 32'hFFFF_FFFF));
        send_access(make_access(CMD_WRITE, 32'h0000_0010, SIZE_WORD, 1'b0, 32'hFFFF_FFFF));
        send_access(make_access(CMD_WRITE, 32'h02FF_FFFF, SIZE_WORD, 1'b0, 32'hFFFF_FFFF));
        send_access(make_access(CMD_READ,  32'h0200_0001, SIZE_BYTE, 1'b1, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h0300_7FFF, SIZE_HALF, 1'b0, 32'h1234_ABCD));
        send_access(make_access(CMD_WRITE, 32'h04FF_FFFF, SIZE_ALT_WORD, 1'b1, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h0500_03FF, SIZE_BYTE, 1'b0, 32'h0000_00A5));
        send_access(make_access(CMD_WRITE, 32'h0601_FFFF, SIZE_BYTE, 1'b0, 32'hFFFF_FF5A));
        send_access(make_access(CMD_READ,  32'h0601_8000, SIZE_WORD, 1'b0, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h0601_7FFE, SIZE_HALF, 1'b1, 32'hCAFE_F00D));
        send_access(make_access(CMD_WRITE, 32'h0700_0101, SIZE_BYTE, 1'b0, 32'hFF));
        send_access(make_access(CMD_WRITE, 32'h0700_03FE, SIZE_HALF, 1'b0, 32'hBEEF));
        send_access(make_access(CMD_READ,  32'h0800_0000, SIZE_WORD, 1'b0, 32'h0));
        send_access(make_access(CMD_READ,  32'h09FF_FFFE, SIZE_HALF, 1'b1, 32'h0));
        send_access(make_access(CMD_READ,  32'h0A00_1234, SIZE_WORD, 1'b1, 32'h0));
        send_access(make_access(CMD_READ,  32'h0DFF_FFFC, SIZE_BYTE, 1'b0, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h0C00_0000, SIZE_WORD, 1'b0, 32'hFFFF_FFFF));
        send_access(make_access(CMD_READ,  32'h0E00_0000, SIZE_BYTE, 1'b0, 32'h0));
        send_access(make_access(CMD_WRITE, 32'h0FFF_FFFF, SIZE_WORD, 1'b1, 32'h5555_AAAA));
        send_access(make_access(CMD_READ,  32'h1000_0000, SIZE_HALF, 1'b0, 32'h0));
        send_access(make_access(CMD_WRITE, 32'hFFFF_FFFF, SIZE_ALT_WORD, 1'b1, 32'hFFFF_FFFF));
        directed_count = 24;
    endtask

    initial
    begin
        logic [WC_W-1:0] wc_value;
        int              phase;
        board          = new();
        send_idle_pct  = 20;
        recv_stall_pct = 72;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 20;
            end
            else if (phase == 4)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            settle();
            if (phase == 0)
                wc_value = '0;
            else if (phase == 1)
                wc_value = '1;
            else
                wc_value = WC_W'($urandom_range(65535));
            write_wait_control(wc_value);
            repeat (RAND_PER_PHASE) send_access(random_access());
        end
        settle();
        $display("Run covered %0d bus accesses (%0d directed) under %0d wait-control settings,",
                 board.noted, directed_count, wc_writes + 1);
        $display("with sender and receiver stalls in turn; %0d result items compared, %0d mismatches.",
                 board.matched, board.mismatches);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
